>>> hdl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for clocked checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text_console_writer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text_console_writer check failed");

`endif

>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, command codes and the types shared by the console modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int CNT_W       = $clog2(CELL_COUNT + 1);
   localparam int ROW_W       = 5;
   localparam int COL_W       = 7;
   localparam int CELL_W      = 16;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] RESET_COLOR  = 8'h0F;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_READ,
      OP_CLEAR,
      OP_NEWLINE,
      OP_PUT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       char_code;
      logic [ROW_W-1:0] read_row;
      logic [COL_W-1:0] read_col;
   } item_type;

   typedef struct packed {
      logic init_clear;
   } back_status_type;

endpackage

>>> hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// An 80x25 character console that prints, reads cells, clears and scrolls.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   request   start / busy           req_command, req_char_code, req_read_row/col
//   response  rsp_strobe (no stall)  rsp_cell_char/color, rsp_cursor_row/col
//   config    csr_write_en           csr_write_data (text color)
//
// In the back end a read or a plain print passes S_READ or S_PUT, a newline or
// a no-op is answered from S_IDLE. A scroll on the last row clears one row of 80
// cells; a clear screen command sweeps all 2000 cells, one per cycle through the
// RAM write port. After reset all 2000 cells are cleared with busy held high.
// A two-entry queue lets start be taken while the back end works.
// ----------------------------------------------------------------------------
module text_console_writer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic [7:0]                req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0] req_read_row,
   input  logic [tcw_pkg::COL_W-1:0] req_read_col,
   output logic                      rsp_strobe,
   output logic [7:0]                rsp_cell_char,
   output logic [7:0]                rsp_cell_color,
   output logic [tcw_pkg::ROW_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0] rsp_cursor_col,
   input  logic                      csr_write_en,
   input  logic [7:0]                csr_write_data
);

   import tcw_pkg::*;

   `include "text_console_writer_assert.svh"

   logic            [7:0] text_color_ff;
   logic                  item_valid;
   logic                  item_pop;
   item_type              item;
   back_status_type       back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_write_en) begin
         text_color_ff <= csr_write_data;
      end
   end

   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .back_status    (back_status),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop)
   );

   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_color     (text_color_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .back_status    (back_status),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_color (rsp_cell_color),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

   `TCW_ASSERT_SAME(a_row_range, rsp_strobe, rsp_cursor_row < ROW_W'(SCREEN_ROWS))
   `TCW_ASSERT_SAME(a_col_range, rsp_strobe, rsp_cursor_col <= COL_W'(SCREEN_COLS))
   `TCW_ASSERT_SAME(a_no_rsp_in_init, back_status.init_clear, !rsp_strobe && busy)
   `TCW_ASSERT_NEXT(a_pop_needs_item, item_pop && !item_valid, 1'b0)

endmodule

>>> hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console front end
// Accepts commands, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tcw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]     req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]     req_read_col,
   input  tcw_pkg::back_status_type      back_status,
   output logic                          item_valid,
   output tcw_pkg::item_type             item,
   input  logic                          item_pop
);

   import tcw_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       full;
   logic       push;
   item_type   new_item;

   always_comb begin
      new_item.char_code = req_char_code;
      new_item.read_row  = req_read_row;
      new_item.read_col  = req_read_col;
      unique case (req_command)
         CMD_PUT: begin
            new_item.op = (req_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
         end
         CMD_READ: begin
            if ((req_read_row < ROW_W'(SCREEN_ROWS)) && (req_read_col < COL_W'(SCREEN_COLS))) begin
               new_item.op = OP_READ;
            end else begin
               new_item.op = OP_NOP;
            end
         end
         CMD_CLEAR: begin
            new_item.op = OP_CLEAR;
         end
         default: begin
            new_item.op = OP_NOP;
         end
      endcase
   end

   assign full       = (count_ff == 2'(QUEUE_DEPTH));
   assign busy       = full || back_status.init_clear;
   assign push       = start && !busy;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console back end
// Carries out queued commands on the screen memory and issues one result each.
// ----------------------------------------------------------------------------
module tcw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    text_color,
   input  logic                          item_valid,
   input  tcw_pkg::item_type             item,
   output logic                          item_pop,
   output tcw_pkg::back_status_type      back_status,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_cell_char,
   output logic [7:0]                    rsp_cell_color,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col
);

   import tcw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_PUT   = 4'b0100,
      S_SWEEP = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] cur_row_ff, cur_row_in;
   logic [COL_W-1:0] cur_col_ff, cur_col_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [CNT_W-1:0] sweep_left_ff, sweep_left_in;
   logic             sweep_put_ff, sweep_put_in;
   logic             sweep_init_ff, sweep_init_in;
   logic [7:0]       char_ff, char_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [7:0]       rsp_color_ff, rsp_color_in;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;
   logic              emit;
   logic              last_row;

   function automatic logic [ADDR_W-1:0] cell_addr(
      input logic [ROW_W-1:0] row,
      input logic [ROW_W-1:0] base,
      input logic [COL_W-1:0] col
   );
      logic [ROW_W:0]    sum;
      logic [ROW_W-1:0]  phys;
      sum = {1'b0, row} + {1'b0, base};
      if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
         sum = sum - (ROW_W+1)'(SCREEN_ROWS);
      end
      phys = sum[ROW_W-1:0];
      return ADDR_W'(ADDR_W'(phys) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(col);
   endfunction

   assign last_row = (cur_row_ff == ROW_W'(SCREEN_ROWS - 1));

   always_comb begin
      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_left_in = sweep_left_ff;
      sweep_put_in  = sweep_put_ff;
      sweep_init_in = sweep_init_ff;
      char_in       = char_ff;
      rsp_char_in   = 8'd0;
      rsp_color_in  = 8'd0;
      emit          = 1'b0;
      item_pop      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_addr_ff;
      ram_wr_data   = {text_color, SPACE_CODE};
      ram_rd_addr   = cell_addr(item.read_row, base_ff, item.read_col);

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               char_in  = item.char_code;
               unique case (item.op)
                  OP_NOP: begin
                     emit = 1'b1;
                  end
                  OP_READ: begin
                     state_in = S_READ;
                  end
                  OP_CLEAR: begin
                     sweep_addr_in = '0;
                     sweep_left_in = CNT_W'(CELL_COUNT);
                     sweep_put_in  = 1'b0;
                     state_in      = S_SWEEP;
                  end
                  OP_NEWLINE, OP_PUT: begin
                     if ((item.op == OP_NEWLINE) || (cur_col_ff == COL_W'(SCREEN_COLS))) begin
                        cur_col_in = '0;
                        if (!last_row) begin
                           cur_row_in = cur_row_ff + ROW_W'(1);
                           if (item.op == OP_NEWLINE) begin
                              emit = 1'b1;
                           end else begin
                              state_in = S_PUT;
                           end
                        end else begin
                           base_in       = last_row && (base_ff == ROW_W'(SCREEN_ROWS - 1))
                                           ? '0 : base_ff + ROW_W'(1);
                           sweep_addr_in = ADDR_W'(ADDR_W'(base_ff) * ADDR_W'(SCREEN_COLS));
                           sweep_left_in = CNT_W'(SCREEN_COLS);
                           sweep_put_in  = (item.op == OP_PUT);
                           state_in      = S_SWEEP;
                        end
                     end else begin
                        state_in = S_PUT;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_char_in  = ram_rd_data[7:0];
            rsp_color_in = ram_rd_data[15:8];
            emit         = 1'b1;
            state_in     = S_IDLE;
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cell_addr(cur_row_ff, base_ff, cur_col_ff);
            ram_wr_data = {text_color, char_ff};
            cur_col_in  = cur_col_ff + COL_W'(1);
            emit        = 1'b1;
            state_in    = S_IDLE;
         end
         S_SWEEP: begin
            ram_wr_en     = 1'b1;
            ram_wr_data   = {sweep_init_ff ? RESET_COLOR : text_color, SPACE_CODE};
            sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
            sweep_left_in = sweep_left_ff - CNT_W'(1);
            if (sweep_left_ff == CNT_W'(1)) begin
               sweep_init_in = 1'b0;
               if (sweep_init_ff) begin
                  state_in = S_IDLE;
               end else if (sweep_put_ff) begin
                  state_in = S_PUT;
               end else begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_strobe_in = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= CNT_W'(CELL_COUNT);
         sweep_put_ff  <= 1'b0;
         sweep_init_ff <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_left_ff <= sweep_left_in;
         sweep_put_ff  <= sweep_put_in;
         sweep_init_ff <= sweep_init_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (emit) begin
         rsp_char_ff  <= rsp_char_in;
         rsp_color_ff <= rsp_color_in;
         rsp_row_ff   <= cur_row_in;
         rsp_col_ff   <= cur_col_in;
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign back_status.init_clear = sweep_init_ff;
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_cell_char          = rsp_char_ff;
   assign rsp_cell_color         = rsp_color_ff;
   assign rsp_cursor_row         = rsp_row_ff;
   assign rsp_cursor_col         = rsp_col_ff;

endmodule
